// File: rtl/core/sswt_pkg.sv
// ----------------------------------------------------------------------------
// sswt_pkg
// Shared constants and types of the step size window tracker.
// ----------------------------------------------------------------------------
package sswt_pkg;

  localparam int WINDOW  = 128;
  localparam int WIN_AW  = $clog2(WINDOW);
  localparam int STEP_W  = 32;
  localparam int CNT_W   = 32;
  localparam int TRIES_W = 8;
  localparam int SUM_W   = STEP_W + WIN_AW;
  // numerator of the 4/5 and 6/5 scaling: up to 6 * (2^32 - 1)
  localparam int NUM_W   = STEP_W + 3;

  // divide by five as a multiply by ceil(2^(NUM_W+3) / 5), taken in chunks
  localparam int CHUNK_W    = 12;
  localparam int N_CHUNKS   = 3;
  localparam int CHUNK_CW   = $clog2(N_CHUNKS + 1);
  localparam int RECIP_W    = CHUNK_W * N_CHUNKS;
  localparam logic [RECIP_W-1:0] RECIP_5 = 36'hC_CCCC_CCCD;
  localparam int ACC_W      = NUM_W + CHUNK_W + 1;
  localparam int QUOT_SHIFT = NUM_W + 3 - (N_CHUNKS - 1) * CHUNK_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PROP_DOWN,
    PROP_UP,
    PROP_KEEP
  } prop_sel_t;

endpackage

// File: rtl/core/sswt_ram.sv
// ----------------------------------------------------------------------------
// sswt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sswt_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/sswt_div5.sv
// ----------------------------------------------------------------------------
// sswt_div5
// Divide by the constant five: reciprocal multiply, one 12-bit chunk a cycle.
// ----------------------------------------------------------------------------
module sswt_div5 import sswt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic [NUM_W-1:0]    x_r, x_nxt;
  logic [RECIP_W-1:0]  m_r, m_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [CHUNK_CW-1:0] cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic [ACC_W-1:0]    part;

  // low chunk first; dropping the low bits each step keeps the floor exact
  always_comb begin
    part     = ACC_W'(x_r) * ACC_W'(m_r[CHUNK_W-1:0]);
    x_nxt    = x_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt   = numer;
      m_nxt   = RECIP_5;
      acc_nxt = '0;
      cnt_nxt = CHUNK_CW'(N_CHUNKS);
    end else if (cnt_r != '0) begin
      m_nxt    = m_r >> CHUNK_W;
      acc_nxt  = (acc_r >> CHUNK_W) + part;
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CHUNK_CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign quot = NUM_W'(acc_r >> QUOT_SHIFT);

endmodule

// File: rtl/core/step_size_window_tracker.sv
// ----------------------------------------------------------------------------
// step_size_window_tracker
// Keeps tried/failed/passed counters and a ring of the last WINDOW (128)
// achieved step sizes; reports window mean, maximum, minimum and a
// proposed trial step size for every request.
//
// Input channel in_*: one request per accepted integrator step (tries,
// achieved and trial step, Q16.16). Result channel out_*: one result per
// request. Both are valid/ready.
// Each request: the achieved size is written into the ring RAM on accept,
// then the ring is scanned one entry a cycle, followed by a drain and a
// set-up state, then the chunked divide-by-five multiply. One request is
// worked at a time, so a new request is taken only after the previous
// result has been loaded into the output register.
// A finished result waits in the output register while in_ready is high
// again; if out_ready is low when the next result is ready, the block holds
// it and accepts nothing until the register frees up.
// After reset the ring RAM is cleared, one entry a cycle, during which
// in_ready stays low.
// ----------------------------------------------------------------------------
module step_size_window_tracker import sswt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TRIES_W-1:0] in_tries,
  input  logic [STEP_W-1:0]  in_achieved_step,
  input  logic [STEP_W-1:0]  in_trial_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CNT_W-1:0]   out_tried_total,
  output logic [CNT_W-1:0]   out_failed_total,
  output logic [CNT_W-1:0]   out_passed_total,
  output logic [STEP_W-1:0]  out_window_mean,
  output logic [STEP_W-1:0]  out_window_max,
  output logic [STEP_W-1:0]  out_window_min,
  output logic [STEP_W-1:0]  out_proposed_step
);

  state_t            state_r, state_nxt;
  logic [WIN_AW-1:0] addr_r, addr_nxt;
  logic [WIN_AW-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  tried_r, failed_r, passed_r;
  logic [STEP_W-1:0] trial_r;
  logic [SUM_W-1:0]  sum_r;
  logic [STEP_W-1:0] hi_r, lo_r;
  logic              rd_vld_r;
  prop_sel_t         sel_r, sel_nxt;
  logic              out_valid_r;
  logic              in_acc, out_load;

  logic              ram_we, ram_re;
  logic [WIN_AW-1:0] ram_waddr;
  logic [STEP_W-1:0] ram_wdata, ram_rdata;

  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_numer, div_quot;
  logic [STEP_W-1:0] prop;

  localparam logic [WIN_AW-1:0] LAST_ADDR = WIN_AW'(WINDOW - 1);

  sswt_ram #(
    .DEPTH (WINDOW),
    .WIDTH (STEP_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  sswt_div5 u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_numer),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    slot_nxt  = slot_r;
    sel_nxt   = sel_r;
    ram_we    = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = in_achieved_step;
    ram_re    = 1'b0;
    div_start = 1'b0;
    div_numer = {1'b0, hi_r, 2'b00};
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = '0;
        addr_nxt  = addr_r + 1'b1;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          ram_we    = 1'b1;
          slot_nxt  = (slot_r == LAST_ADDR) ? '0 : slot_r + 1'b1;
          addr_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram_re   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        div_start = 1'b1;
        priority if (trial_r > hi_r) begin
          sel_nxt = PROP_DOWN;
        end else if (trial_r < hi_r) begin
          sel_nxt   = PROP_UP;
          div_numer = {1'b0, lo_r, 2'b00} + {2'b00, lo_r, 1'b0};
        end else begin
          sel_nxt = PROP_KEEP;
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    unique case (sel_r)
      PROP_DOWN: prop = div_quot[STEP_W-1:0];
      PROP_UP:   prop = (|div_quot[NUM_W-1:STEP_W]) ? '1 : div_quot[STEP_W-1:0];
      PROP_KEEP: prop = trial_r;
      default:   prop = trial_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      slot_r      <= '0;
      tried_r     <= '0;
      failed_r    <= '0;
      passed_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      sel_r       <= PROP_KEEP;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      slot_r   <= slot_nxt;
      sel_r    <= sel_nxt;
      rd_vld_r <= ram_re;
      if (in_acc) begin
        tried_r  <= tried_r + {{(CNT_W-TRIES_W){1'b0}}, in_tries};
        failed_r <= failed_r + {{(CNT_W-TRIES_W){1'b0}}, in_tries} - CNT_W'(1);
        passed_r <= passed_r + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // window statistics, gathered as the ring streams out of the RAM
  always_ff @(posedge clk) begin
    if (in_acc) begin
      trial_r <= in_trial_step;
      sum_r   <= '0;
      hi_r    <= '0;
      lo_r    <= '1;
    end else if (rd_vld_r) begin
      sum_r <= sum_r + {{WIN_AW{1'b0}}, ram_rdata};
      if (ram_rdata > hi_r) begin
        hi_r <= ram_rdata;
      end
      if (ram_rdata < lo_r) begin
        lo_r <= ram_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tried_total   <= tried_r;
      out_failed_total  <= failed_r;
      out_passed_total  <= passed_r;
      out_window_mean   <= sum_r[SUM_W-1:WIN_AW];
      out_window_max    <= hi_r;
      out_window_min    <= lo_r;
      out_proposed_step <= prop;
    end
  end

  assign out_valid = out_valid_r;

endmodule
